// ===== design/muee_pkg.sv =====
package muee_pkg;

  localparam int unsigned NODE_ID_BITS_DEF  = 16;
  localparam int unsigned EDGE_CAPACITY_DEF = 4096;
  localparam int unsigned NODE_W            = 16;
  localparam int unsigned LINE_ID_W         = 12;
  localparam int unsigned QUEUE_DEPTH       = 4;

  typedef struct packed {
    logic clear;
    logic last;
  } edge_flags_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_NEW  = 5'b01000,
    S_END  = 5'b10000
  } back_state_e;

endpackage

// ===== design/mesh_unique_edge_extractor_top.sv =====
// Emits every edge of a triangle and quadrilateral mesh once, in order of first appearance,
// with a sequential line id; one element is taken per request and yields zero to four results,
// the last of them marked. The front splits an element into normalized edges at one per cycle,
// while the queue is not full, into a four-entry queue; the back searches the edge store
// linearly through a single RAM read port, reading and then comparing each stored edge. A new
// edge is held in a pending register so that the last result of an element can be marked.
// Setting first_element restarts the store and ids.
module mesh_unique_edge_extractor_top #(
  parameter int unsigned NODE_ID_BITS  = muee_pkg::NODE_ID_BITS_DEF,
  parameter int unsigned EDGE_CAPACITY = muee_pkg::EDGE_CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           first_element_i,
  input  logic                           is_quad_i,
  input  logic [muee_pkg::NODE_W-1:0]    node_a_i,
  input  logic [muee_pkg::NODE_W-1:0]    node_b_i,
  input  logic [muee_pkg::NODE_W-1:0]    node_c_i,
  input  logic [muee_pkg::NODE_W-1:0]    node_d_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [muee_pkg::LINE_ID_W-1:0] line_id_o,
  output logic [muee_pkg::NODE_W-1:0]    node_low_o,
  output logic [muee_pkg::NODE_W-1:0]    node_high_o,
  output logic                           table_full_o,
  output logic                           last_of_run_o
);

  localparam int unsigned NW = NODE_ID_BITS;
  localparam int unsigned QW = 2 * NW + 2;

  logic                  push, pop, full, empty;
  muee_pkg::edge_flags_t f_flags, b_flags;
  logic [NW-1:0]         f_lo, f_hi, b_lo, b_hi;

  muee_front #(
    .NODE_ID_BITS (NODE_ID_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .first_element_i (first_element_i),
    .is_quad_i       (is_quad_i),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .node_c_i        (node_c_i),
    .node_d_i        (node_d_i),
    .q_full_i        (full),
    .q_push_o        (push),
    .q_flags_o       (f_flags),
    .q_lo_o          (f_lo),
    .q_hi_o          (f_hi)
  );

  muee_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_flags, f_lo, f_hi}),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o ({b_flags, b_lo, b_hi}),
    .empty_o (empty)
  );

  muee_back #(
    .NODE_ID_BITS  (NODE_ID_BITS),
    .EDGE_CAPACITY (EDGE_CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (empty),
    .q_pop_o       (pop),
    .q_flags_i     (b_flags),
    .q_lo_i        (b_lo),
    .q_hi_i        (b_hi),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_id_o     (line_id_o),
    .node_low_o    (node_low_o),
    .node_high_o   (node_high_o),
    .table_full_o  (table_full_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== design/muee_ram.sv =====
module muee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/muee_queue.sv =====
module muee_queue #(
  parameter int unsigned WIDTH = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned DEPTH = muee_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = data_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/muee_front.sv =====
module muee_front #(
  parameter int unsigned NODE_ID_BITS = muee_pkg::NODE_ID_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        first_element_i,
  input  logic                        is_quad_i,
  input  logic [muee_pkg::NODE_W-1:0] node_a_i,
  input  logic [muee_pkg::NODE_W-1:0] node_b_i,
  input  logic [muee_pkg::NODE_W-1:0] node_c_i,
  input  logic [muee_pkg::NODE_W-1:0] node_d_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output muee_pkg::edge_flags_t       q_flags_o,
  output logic [NODE_ID_BITS-1:0]     q_lo_o,
  output logic [NODE_ID_BITS-1:0]     q_hi_o
);

  localparam int unsigned NW = NODE_ID_BITS;

  logic          busy_q;
  logic          first_q, quad_q;
  logic [1:0]    idx_q;
  logic [NW-1:0] nd_q [4];
  logic [1:0]    last_idx;
  logic [1:0]    nxt_idx;
  logic [NW-1:0] p, q;

  assign in_stall_o = busy_q;
  assign last_idx   = quad_q ? 2'd3 : 2'd2;
  assign nxt_idx    = (idx_q == last_idx) ? 2'd0 : idx_q + 2'd1;
  assign p          = nd_q[idx_q];
  assign q          = nd_q[nxt_idx];
  assign q_lo_o     = (p < q) ? p : q;
  assign q_hi_o     = (p < q) ? q : p;
  assign q_push_o   = busy_q && !q_full_i;
  assign q_flags_o  = '{clear: first_q && (idx_q == 2'd0), last: idx_q == last_idx};

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !busy_q) begin
      nd_q[0] <= NW'(node_a_i);
      nd_q[1] <= NW'(node_b_i);
      nd_q[2] <= NW'(node_c_i);
      nd_q[3] <= NW'(node_d_i);
      first_q <= first_element_i;
      quad_q  <= is_quad_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (!busy_q) begin
      if (in_valid_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end
    end else if (!q_full_i) begin
      if (idx_q == last_idx) begin
        busy_q <= 1'b0;
      end
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// ===== design/muee_back.sv =====
module muee_back #(
  parameter int unsigned NODE_ID_BITS  = muee_pkg::NODE_ID_BITS_DEF,
  parameter int unsigned EDGE_CAPACITY = muee_pkg::EDGE_CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  output logic                           q_pop_o,
  input  muee_pkg::edge_flags_t          q_flags_i,
  input  logic [NODE_ID_BITS-1:0]        q_lo_i,
  input  logic [NODE_ID_BITS-1:0]        q_hi_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [muee_pkg::LINE_ID_W-1:0] line_id_o,
  output logic [muee_pkg::NODE_W-1:0]    node_low_o,
  output logic [muee_pkg::NODE_W-1:0]    node_high_o,
  output logic                           table_full_o,
  output logic                           last_of_run_o
);

  localparam int unsigned NW = NODE_ID_BITS;
  localparam int unsigned AW = $clog2(EDGE_CAPACITY);
  localparam int unsigned CW = $clog2(EDGE_CAPACITY + 1);
  localparam int unsigned LW = muee_pkg::LINE_ID_W;
  localparam int unsigned OW = muee_pkg::NODE_W;

  muee_pkg::back_state_e state_q, state_d;

  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [NW-1:0]   lo_q, hi_q;
  logic            last_q;
  logic            pend_q, pend_d;
  logic [LW-1:0]   pend_id_q;
  logic [NW-1:0]   pend_lo_q, pend_hi_q;
  logic            pend_full_q;
  logic            out_valid_q, out_valid_d;
  logic            out_load, out_last;
  logic            slot_free;
  logic            store_full;
  logic            ram_we, ram_re;
  logic [2*NW-1:0] ram_rdata;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign store_full = (count_q == CW'(EDGE_CAPACITY));
  assign q_pop_o    = (state_q == muee_pkg::S_IDLE) && !q_empty_i;
  assign ram_re     = (state_q == muee_pkg::S_RD);
  assign ram_we     = (state_q == muee_pkg::S_NEW) && (!pend_q || slot_free) && !store_full;

  muee_ram #(
    .WIDTH (2 * NW),
    .DEPTH (EDGE_CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({lo_q, hi_q}),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    out_load    = 1'b0;
    out_last    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      muee_pkg::S_IDLE: begin
        if (!q_empty_i) begin
          idx_d = '0;
          if (q_flags_i.clear) begin
            count_d = '0;
          end
          if (q_flags_i.clear || count_q == '0) begin
            state_d = muee_pkg::S_NEW;
          end else begin
            state_d = muee_pkg::S_RD;
          end
        end
      end
      muee_pkg::S_RD: begin
        state_d = muee_pkg::S_CMP;
      end
      muee_pkg::S_CMP: begin
        if (ram_rdata == {lo_q, hi_q}) begin
          state_d = muee_pkg::S_END;
        end else if (idx_q + 1'b1 == count_q) begin
          state_d = muee_pkg::S_NEW;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = muee_pkg::S_RD;
        end
      end
      muee_pkg::S_NEW: begin
        if (!pend_q || slot_free) begin
          if (pend_q) begin
            out_load = 1'b1;
          end
          pend_d = 1'b1;
          if (!store_full) begin
            count_d = count_q + 1'b1;
          end
          state_d = muee_pkg::S_END;
        end
      end
      muee_pkg::S_END: begin
        if (!last_q || !pend_q) begin
          state_d = muee_pkg::S_IDLE;
        end else if (slot_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          pend_d   = 1'b0;
          state_d  = muee_pkg::S_IDLE;
        end
      end
      default: state_d = muee_pkg::S_IDLE;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      lo_q   <= q_lo_i;
      hi_q   <= q_hi_i;
      last_q <= q_flags_i.last;
    end
    if (state_q == muee_pkg::S_NEW && (!pend_q || slot_free)) begin
      pend_lo_q   <= lo_q;
      pend_hi_q   <= hi_q;
      pend_full_q <= store_full;
      pend_id_q   <= store_full ? '0 : LW'(count_q);
    end
    if (out_load) begin
      line_id_o     <= pend_id_q;
      node_low_o    <= OW'(pend_lo_q);
      node_high_o   <= OW'(pend_hi_q);
      table_full_o  <= pend_full_q;
      last_of_run_o <= out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= muee_pkg::S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== bench/testbench.sv =====
module testbench;

  localparam int unsigned NW = muee_pkg::NODE_W;
  localparam int unsigned LW = muee_pkg::LINE_ID_W;

  typedef struct {
    logic [LW-1:0] line_id;
    logic [NW-1:0] node_low;
    logic [NW-1:0] node_high;
    logic          table_full;
    logic          last_of_run;
  } edge_out_t;

  typedef struct {
    logic          first;
    logic          quad;
    logic [NW-1:0] a, b, c, d;
    bit            typed;
    int            n_typed;
    logic [LW-1:0] id_typed;
  } elem_row_t;

  localparam int CAPACITY  = muee_pkg::EDGE_CAPACITY_DEF;
  localparam int NRAND     = 130;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall;
  logic first_element = 0, is_quad = 0;
  logic [NW-1:0] node_a = 0, node_b = 0, node_c = 0, node_d = 0;
  logic out_valid, out_stall = 0;
  logic [LW-1:0] line_id;
  logic [NW-1:0] node_low, node_high;
  logic table_full, last_of_run;

  edge_out_t pending_edges[$];
  logic [NW-1:0] known_low[CAPACITY];
  logic [NW-1:0] known_high[CAPACITY];
  int known_count = 0;
  int errors = 0;
  int accepted = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  bit hold_request = 0;

  always #5 clk = ~clk;

  mesh_unique_edge_extractor_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .first_element_i(first_element), .is_quad_i(is_quad),
    .node_a_i(node_a), .node_b_i(node_b), .node_c_i(node_c), .node_d_i(node_d),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .line_id_o(line_id), .node_low_o(node_low), .node_high_o(node_high),
    .table_full_o(table_full), .last_of_run_o(last_of_run)
  );

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic add_edge(input logic [NW-1:0] p, input logic [NW-1:0] q,
                          inout int n);
    logic [NW-1:0] lo, hi;
    edge_out_t r;
    bit seen;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    seen = 0;
    for (int i = 0; i < known_count; i++)
      if (known_low[i] == lo && known_high[i] == hi) seen = 1;
    if (!seen) begin
      r.node_low = lo;
      r.node_high = hi;
      r.last_of_run = 0;
      if (known_count < CAPACITY) begin
        r.line_id = known_count[LW-1:0];
        r.table_full = 0;
        known_low[known_count] = lo;
        known_high[known_count] = hi;
        known_count++;
      end else begin
        r.line_id = 0;
        r.table_full = 1;
      end
      pending_edges.push_back(r);
      n++;
    end
  endtask

  task automatic predict_edges(input logic first, input logic quad,
                               input logic [NW-1:0] a, b, c, d, output int n);
    n = 0;
    if (first) known_count = 0;
    add_edge(a, b, n);
    add_edge(b, c, n);
    if (quad) begin
      add_edge(c, d, n);
      add_edge(d, a, n);
    end else begin
      add_edge(c, a, n);
    end
    if (n > 0) pending_edges[$].last_of_run = 1;
  endtask

  // Predictor and typed checks run on every accepted request.
  elem_row_t cur_row;
  always @(posedge clk) begin
    int n;
    if (in_valid && !in_stall) begin
      predict_edges(first_element, is_quad, node_a, node_b, node_c, node_d, n);
      if (cur_row.typed) begin
        if (n != cur_row.n_typed) report($sformatf("element gives %0d edges", n));
        else if (n > 0 && pending_edges[pending_edges.size() - n].line_id != cur_row.id_typed)
          report("first line id of element");
      end
      accepted++;
    end
  end

  always @(posedge clk) begin
    edge_out_t e;
    if (out_valid && !out_stall) begin
      if (pending_edges.size() == 0) begin
        report("unexpected edge");
      end else begin
        e = pending_edges.pop_front();
        if (line_id !== e.line_id) report($sformatf("line_id %0d exp %0d", line_id, e.line_id));
        if (node_low !== e.node_low) report("node_low");
        if (node_high !== e.node_high) report("node_high");
        if (table_full !== e.table_full) report("table_full");
        if (last_of_run !== e.last_of_run) report("last_of_run");
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_request = 0;
        out_stall <= 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_element(input elem_row_t row);
    cur_row <= row;
    first_element <= row.first;
    is_quad <= row.quad;
    node_a <= row.a;
    node_b <= row.b;
    node_c <= row.c;
    node_d <= row.d;
    in_valid <= 1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic elem_row_t mk(logic f, logic q, int a, int b, int c, int d,
                                   bit t = 0, int n = 0, int id = 0);
    elem_row_t r;
    r.first = f; r.quad = q;
    r.a = NW'(a); r.b = NW'(b); r.c = NW'(c); r.d = NW'(d);
    r.typed = t; r.n_typed = n; r.id_typed = LW'(id);
    return r;
  endfunction

  elem_row_t directed[] = '{
    mk(1, 0, 0, 0, 0, 0, 1, 1, 0),
    mk(0, 0, 0, 0, 0, 65535, 1, 0, 0),
    mk(0, 0, 65535, 65535, 65535, 0, 1, 1, 1),
    mk(0, 1, 0, 65535, 0, 65535, 1, 1, 2),
    mk(0, 1, 65535, 0, 65535, 0, 1, 0, 0),
    mk(0, 0, 1, 2, 3, 9, 1, 3, 3),
    mk(0, 0, 3, 2, 1, 7, 1, 0, 0),
    mk(0, 1, 1, 2, 3, 4, 1, 2, 6),
    mk(0, 1, 10, 11, 12, 13),
    mk(0, 0, 5, 5, 6, 0),
    mk(0, 1, 43690, 21845, 43690, 21845),
    mk(1, 0, 1, 2, 3, 4, 1, 3, 0),
    mk(0, 1, 2, 1, 4, 3),
    mk(1, 1, 65535, 32768, 255, 256, 1, 4, 0),
    mk(0, 0, 32768, 65535, 7, 1)
  };

  function automatic logic [NW-1:0] pick_node(int base);
    if ($urandom_range(0, 9) == 0) return NW'($urandom_range(0, 65535));
    return NW'(base + $urandom_range(0, 12));
  endfunction

  initial begin
    elem_row_t r;
    int base;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) send_element(directed[i]);
    base = 0;
    for (int i = 0; i < NRAND; i++) begin
      if (i == 40) hold_request = 1;
      if (i > NRAND - 20) quiet = 1;
      r = mk(0, 0, 0, 0, 0, 0);
      if (i % 8 == 0 || $urandom_range(0, 19) == 0) begin
        r.first = 1;
        base = $urandom_range(0, 65535 - 12);
      end
      r.quad = $urandom_range(0, 1);
      r.a = pick_node(base);
      r.b = pick_node(base);
      r.c = pick_node(base);
      r.d = r.quad ? pick_node(base) : NW'($urandom_range(0, 65535));
      send_element(r);
    end
    in_valid <= 0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (pending_edges.size() != 0) report("edges never delivered");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
